>>> hw/rtl/dva_pkg.sv
package dva_pkg;

	localparam int VALUE_WIDTH = 58;
	localparam int CHAR_WIDTH = 7;
	localparam int BCD_DIGITS = 18;
	localparam int BCD_BITS = 4 * BCD_DIGITS;
	localparam int CONV_BITS_PER_STEP = 4;
	localparam int CONV_STEPS = (VALUE_WIDTH + CONV_BITS_PER_STEP - 1) / CONV_BITS_PER_STEP;
	localparam int CONV_WIDTH = CONV_STEPS * CONV_BITS_PER_STEP;
	localparam int CONV_CNT_WIDTH = $clog2(CONV_STEPS);
	localparam int MAX_RESULTS = 20;
	localparam int COUNT_WIDTH = $clog2(MAX_RESULTS);
	localparam int DIGIT_IDX_WIDTH = $clog2(BCD_DIGITS);
	localparam int POS_WIDTH = 6;
	localparam int LZ_WIDTH = 4;

	localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 7'h2d;
	localparam logic [CHAR_WIDTH-1:0] ASCII_POINT = 7'h2e;
	localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 7'h30;
	localparam logic [3:0] DIGIT_NINE = 4'd9;

	typedef enum logic [1:0] {
		CH_MINUS,
		CH_ZERO,
		CH_POINT,
		CH_DIGIT
	} char_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_PREP,
		ST_SIGN,
		ST_LEAD_ZERO,
		ST_LEAD_POINT,
		ST_LEAD_ZEROS,
		ST_DIGIT,
		ST_POINT
	} state_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic prep;
		logic emit;
		char_sel_t sel;
		logic last;
		logic lz_step;
		logic pos_step;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic zero;
		logic neg;
		logic below_one;
		logic lz_zero;
		logic lz_one;
		logic digit_last;
		logic at_point;
		logic count_last;
		logic out_free;
	} sts_t;

endpackage

>>> hw/rtl/dva_ctrl.sv
module dva_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dva_pkg::sts_t sts,
	output dva_pkg::cmd_t cmd
);
	import dva_pkg::*;

	state_t state_q;
	state_t state_d;
	state_t nxt;
	logic emitting;
	logic last_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		state_d = state_q;
		nxt = state_q;
		emitting = 1'b0;
		last_raw = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_done) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (sts.zero) begin
					state_d = ST_LEAD_ZERO;
				end else if (sts.neg) begin
					state_d = ST_SIGN;
				end else if (sts.below_one) begin
					state_d = ST_LEAD_ZERO;
				end else begin
					state_d = ST_DIGIT;
				end
			end
			ST_SIGN: begin
				emitting = 1'b1;
				cmd.sel = CH_MINUS;
				nxt = sts.below_one ? ST_LEAD_ZERO : ST_DIGIT;
			end
			ST_LEAD_ZERO: begin
				emitting = 1'b1;
				cmd.sel = CH_ZERO;
				last_raw = sts.zero;
				nxt = ST_LEAD_POINT;
			end
			ST_LEAD_POINT: begin
				emitting = 1'b1;
				cmd.sel = CH_POINT;
				nxt = sts.lz_zero ? ST_DIGIT : ST_LEAD_ZEROS;
			end
			ST_LEAD_ZEROS: begin
				emitting = 1'b1;
				cmd.sel = CH_ZERO;
				nxt = sts.lz_one ? ST_DIGIT : ST_LEAD_ZEROS;
			end
			ST_DIGIT: begin
				emitting = 1'b1;
				cmd.sel = CH_DIGIT;
				last_raw = sts.digit_last;
				nxt = sts.at_point ? ST_POINT : ST_DIGIT;
			end
			ST_POINT: begin
				emitting = 1'b1;
				cmd.sel = CH_POINT;
				nxt = ST_DIGIT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (emitting && sts.out_free) begin
			cmd.emit = 1'b1;
			cmd.last = last_raw | sts.count_last;
			cmd.lz_step = (state_q == ST_LEAD_ZEROS);
			cmd.pos_step = (state_q == ST_DIGIT);
			state_d = cmd.last ? ST_IDLE : nxt;
		end
	end

endmodule

>>> hw/rtl/dva_datapath.sv
module dva_datapath #(
	parameter int FRACTION_DIGITS = 8,
	parameter int SIGNIFICANT_DIGITS = 10
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic signed [dva_pkg::VALUE_WIDTH-1:0]     value,
	input  dva_pkg::cmd_t                              cmd,
	output dva_pkg::sts_t                              sts,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic        [dva_pkg::CHAR_WIDTH-1:0]      character,
	output logic                                       last
);
	import dva_pkg::*;

	localparam int START_POS = FRACTION_DIGITS + 8;
	localparam logic signed [POS_WIDTH-1:0] POINT_POS = POS_WIDTH'(FRACTION_DIGITS);

	logic [VALUE_WIDTH-1:0] value_u;
	logic [VALUE_WIDTH-1:0] mag;
	logic [CONV_WIDTH-1:0] mag_q;
	logic [CONV_WIDTH-1:0] mag_next;
	logic [BCD_BITS-1:0] bcd_q;
	logic [BCD_BITS-1:0] bcd_next;
	logic [CONV_CNT_WIDTH-1:0] conv_cnt_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic neg_q;
	logic zero_q;
	logic signed [POS_WIDTH-1:0] pos_q;
	logic signed [POS_WIDTH-1:0] end_pos_q;
	logic signed [POS_WIDTH-1:0] lead_pos;
	logic [LZ_WIDTH-1:0] lz_q;
	logic [BCD_DIGITS-1:0] nz;
	logic sat;
	logic [DIGIT_IDX_WIDTH-1:0] lead;
	logic below_one;
	logic nonzero_below;
	logic [3:0] digit_sel;
	logic [3:0] digit;
	logic [CHAR_WIDTH-1:0] char_d;
	logic out_valid_q;
	logic [CHAR_WIDTH-1:0] char_q;
	logic last_q;
	logic out_free;

	assign value_u = value;
	assign mag = value[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;

	always_comb begin
		bcd_next = bcd_q;
		mag_next = mag_q;
		for (int s = 0; s < CONV_BITS_PER_STEP; s++) begin
			for (int i = 0; i < BCD_DIGITS; i++) begin
				if (bcd_next[4*i +: 4] >= 4'd5) begin
					bcd_next[4*i +: 4] = bcd_next[4*i +: 4] + 4'd3;
				end
			end
			bcd_next = {bcd_next[BCD_BITS-2:0], mag_next[CONV_WIDTH-1]};
			mag_next = {mag_next[CONV_WIDTH-2:0], 1'b0};
		end
	end

	always_comb begin
		sat = 1'b0;
		lead = '0;
		nonzero_below = 1'b0;
		digit_sel = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			nz[i] = |bcd_q[4*i +: 4];
			if (i > START_POS && nz[i]) begin
				sat = 1'b1;
			end
			if (i <= START_POS && nz[i]) begin
				lead = DIGIT_IDX_WIDTH'(i);
			end
			if (int'(pos_q) > i && nz[i]) begin
				nonzero_below = 1'b1;
			end
			if (int'(pos_q) == i) begin
				digit_sel = bcd_q[4*i +: 4];
			end
		end
		if (sat) begin
			lead = DIGIT_IDX_WIDTH'(START_POS);
		end
	end

	assign below_one = !sat && (int'(lead) < FRACTION_DIGITS);
	assign lead_pos = POS_WIDTH'(lead);
	assign digit = sat ? DIGIT_NINE : digit_sel;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (cmd.sel)
			CH_MINUS: char_d = ASCII_MINUS;
			CH_ZERO: char_d = ASCII_ZERO;
			CH_POINT: char_d = ASCII_POINT;
			CH_DIGIT: char_d = ASCII_ZERO + {3'b000, digit};
			default: char_d = ASCII_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_cnt_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				conv_cnt_q <= '0;
				count_q <= '0;
			end else begin
				if (cmd.conv_step) begin
					conv_cnt_q <= conv_cnt_q + 1'b1;
				end
				if (cmd.emit) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= {{(CONV_WIDTH - VALUE_WIDTH){1'b0}}, mag};
			bcd_q <= '0;
			neg_q <= value[VALUE_WIDTH-1];
			zero_q <= (value_u == '0);
		end else if (cmd.conv_step) begin
			mag_q <= mag_next;
			bcd_q <= bcd_next;
		end
		if (cmd.prep) begin
			pos_q <= lead_pos;
			end_pos_q <= lead_pos - POS_WIDTH'(SIGNIFICANT_DIGITS - 1);
			lz_q <= LZ_WIDTH'(FRACTION_DIGITS - 1) - LZ_WIDTH'(lead);
		end else begin
			if (cmd.pos_step) begin
				pos_q <= pos_q - 1'b1;
			end
			if (cmd.lz_step) begin
				lz_q <= lz_q - 1'b1;
			end
		end
		if (cmd.emit) begin
			char_q <= char_d;
			last_q <= cmd.last;
		end
	end

	always_comb begin
		sts.conv_done = (conv_cnt_q == CONV_CNT_WIDTH'(CONV_STEPS - 1));
		sts.zero = zero_q;
		sts.neg = neg_q;
		sts.below_one = below_one;
		sts.lz_zero = (lz_q == '0);
		sts.lz_one = (lz_q == LZ_WIDTH'(1));
		sts.digit_last = (pos_q == end_pos_q)
			|| (!sat && !nonzero_below && (pos_q <= POINT_POS));
		sts.at_point = (pos_q == POINT_POS);
		sts.count_last = (count_q == COUNT_WIDTH'(MAX_RESULTS - 1));
		sts.out_free = out_free;
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last = last_q;

endmodule

>>> hw/rtl/decimal_value_to_ascii_unit.sv
// A request is converted to BCD, four magnitude bits per cycle, and then set up for output.
// The first character is then loaded into the output register.
// Characters follow one per cycle while the consumer keeps up, and the next request is
// accepted once the last character is loaded.
// The asynchronous active-low reset clears the state machine, counters and output valid.
module decimal_value_to_ascii_unit #(
	parameter int FRACTION_DIGITS = 8,
	parameter int SIGNIFICANT_DIGITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [dva_pkg::VALUE_WIDTH-1:0] value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic        [dva_pkg::CHAR_WIDTH-1:0]  character,
	output logic                                   last
);
	import dva_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dva_datapath #(
		.FRACTION_DIGITS    (FRACTION_DIGITS),
		.SIGNIFICANT_DIGITS (SIGNIFICANT_DIGITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

endmodule
